[sv/hte_pkg.sv]
// Package of the head/tail frame extractor: shared widths, types, register
// indexes and the small helper functions for pattern bytes and lengths.
// No dependencies.
package hte_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 4;
   localparam int PAT_W      = 64;
   localparam int CSR_ADDR_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [PAT_W-1:0]  pattern_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HEAD_LENGTH  = 8'd0,
      CSR_HEAD_PATTERN = 8'd1,
      CSR_TAIL_LENGTH  = 8'd2,
      CSR_TAIL_PATTERN = 8'd3
   } csr_index_type;

   // Outcome of one matcher step.
   typedef struct packed {
      len_type count;
      logic    done;
   } match_result_type;

   // Byte number pos of a pattern, first byte in the low bits.
   function automatic byte_type pattern_byte(pattern_type pattern, logic [2:0] pos);
      return pattern[{pos, 3'b000} +: BYTE_W];
   endfunction

   // A zero length acts as one, a length above the limit acts as the limit.
   function automatic len_type eff_length(len_type len, len_type max_len);
      len_type result;
      if (len == '0) begin
         result = len_type'(1);
      end else if (len > max_len) begin
         result = max_len;
      end else begin
         result = len;
      end
      return result;
   endfunction

endpackage

[sv/hte_if.sv]
// Channel interfaces of the head/tail frame extractor: input bytes, frame
// bytes and configuration writes, each with valid and ready.
// Depends on hte_pkg.
interface hte_req_if import hte_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface hte_rsp_if import hte_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     frame_first;
   logic     frame_last;

   modport source (output valid, output out_byte, output frame_first,
                   output frame_last, input ready);
   modport sink   (input valid, input out_byte, input frame_first,
                   input frame_last, output ready);
endinterface

interface hte_csr_if import hte_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   pattern_type           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/head_tail_frame_extractor.sv]
// Top level of the head/tail frame extractor: configuration registers,
// match state, head replay and the result register.
// Depends on hte_pkg, hte_if and hte_matcher.

// The block hunts a byte stream for a configured head sequence and passes on
// every frame from its head up to and including the configured end sequence;
// bytes between frames are dropped. One byte is taken per cycle when ready.
// While hunting, a byte that does not complete the head produces nothing;
// the byte that completes the head produces the whole head, head_length
// transfers on the result channel with frame_first on the first of them.
// Inside a frame every byte is passed on in the cycle after it arrives, and
// the byte that completes the end sequence carries frame_last. The matcher
// restarts on a mismatch and compares the same byte with the first pattern
// byte again, without backing up in the stream. The head is replayed from the
// head_pattern register at one byte per cycle while the result register is
// free, and the input is held off until the whole head is shown; otherwise
// the result register lets a new byte in every cycle in which the previous
// result is taken or none is waiting. Lengths of zero act as one and lengths
// above MAX_HEAD_BYTES or MAX_TAIL_BYTES act as that limit. Configuration
// writes are always taken; writes to an unknown index are ignored, and
// registers are to be written only while the block is idle.
module head_tail_frame_extractor import hte_pkg::*; #(
   parameter int MAX_HEAD_BYTES = 8,
   parameter int MAX_TAIL_BYTES = 8
) (
   input  logic  clock,
   input  logic  reset,
   hte_req_if.sink   req,
   hte_rsp_if.source rsp,
   hte_csr_if.sink   csr
);

   localparam len_type HEAD_LIMIT = len_type'(MAX_HEAD_BYTES);
   localparam len_type TAIL_LIMIT = len_type'(MAX_TAIL_BYTES);

   // Configuration registers.
   len_type     head_length_ff, head_length_in;
   pattern_type head_pattern_ff, head_pattern_in;
   len_type     tail_length_ff, tail_length_in;
   pattern_type tail_pattern_ff, tail_pattern_in;

   // Match state.
   logic    inside_ff, inside_in;
   len_type count_ff, count_in;

   // Head replay: position of the next head byte to show.
   logic    burst_ff, burst_in;
   len_type burst_pos_ff, burst_pos_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type out_byte_ff, out_byte_in;
   logic     first_ff, first_in;
   logic     last_ff, last_in;

   len_type          head_len;
   len_type          tail_len;
   pattern_type      match_pattern;
   len_type          match_length;
   match_result_type match;
   logic             out_free;
   logic             req_take;

   assign head_len = eff_length(head_length_ff, HEAD_LIMIT);
   assign tail_len = eff_length(tail_length_ff, TAIL_LIMIT);

   // One matcher serves both sequences, since only one is looked for at a time.
   assign match_pattern = inside_ff ? tail_pattern_ff : head_pattern_ff;
   assign match_length  = inside_ff ? tail_len : head_len;

   hte_matcher u_matcher (
      .pattern (match_pattern),
      .length  (match_length),
      .count   (count_ff),
      .data    (req.in_byte),
      .result  (match)
   );

   // The result register may be loaded when it is empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = out_free && !burst_ff;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.frame_first = first_ff;
   assign rsp.frame_last  = last_ff;

   // Configuration writes.
   always_comb begin
      head_length_in  = head_length_ff;
      head_pattern_in = head_pattern_ff;
      tail_length_in  = tail_length_ff;
      tail_pattern_in = tail_pattern_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_HEAD_LENGTH:  head_length_in  = csr.data[LEN_W-1:0];
            CSR_HEAD_PATTERN: head_pattern_in = csr.data;
            CSR_TAIL_LENGTH:  tail_length_in  = csr.data[LEN_W-1:0];
            CSR_TAIL_PATTERN: tail_pattern_in = csr.data;
            default: ;
         endcase
      end
   end

   // Match state, head replay and result register.
   always_comb begin
      inside_in    = inside_ff;
      count_in     = count_ff;
      burst_in     = burst_ff;
      burst_pos_in = burst_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      first_in     = first_ff;
      last_in      = last_ff;

      priority if (burst_ff && out_free) begin
         // Replay the remaining head bytes one per cycle while the result register is free.
         rsp_valid_in = 1'b1;
         out_byte_in  = pattern_byte(head_pattern_ff, burst_pos_ff[2:0]);
         first_in     = 1'b0;
         last_in      = 1'b0;
         burst_pos_in = len_type'(burst_pos_ff + len_type'(1));
         burst_in     = (burst_pos_in != head_len);
      end else if (req_take) begin
         count_in = match.count;
         if (!inside_ff) begin
            if (match.done) begin
               // Head complete: show its first byte now, the rest follow.
               inside_in    = 1'b1;
               rsp_valid_in = 1'b1;
               out_byte_in  = pattern_byte(head_pattern_ff, 3'd0);
               first_in     = 1'b1;
               last_in      = 1'b0;
               burst_pos_in = len_type'(1);
               burst_in     = (head_len != len_type'(1));
            end
         end else begin
            rsp_valid_in = 1'b1;
            out_byte_in  = req.in_byte;
            first_in     = 1'b0;
            last_in      = match.done;
            if (match.done) begin
               inside_in = 1'b0;
            end
         end
      end else begin
         // Nothing new to show; the register empties once taken.
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_length_ff  <= len_type'(1);
         head_pattern_ff <= '0;
         tail_length_ff  <= len_type'(1);
         tail_pattern_ff <= '0;
         inside_ff       <= 1'b0;
         count_ff        <= '0;
         burst_ff        <= 1'b0;
         burst_pos_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         head_length_ff  <= head_length_in;
         head_pattern_ff <= head_pattern_in;
         tail_length_ff  <= tail_length_in;
         tail_pattern_ff <= tail_pattern_in;
         inside_ff       <= inside_in;
         count_ff        <= count_in;
         burst_ff        <= burst_in;
         burst_pos_ff    <= burst_pos_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload of the result register needs no reset.
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
   end

endmodule

[sv/hte_matcher.sv]
// One step of the naive restart matcher used for both head and end sequences.
// Purely combinational; depends on hte_pkg.
module hte_matcher import hte_pkg::*; (
   input  pattern_type      pattern,
   input  len_type          length,
   input  len_type          count,
   input  byte_type         data,
   output match_result_type result
);

   len_type start_count;
   len_type next_count;

   always_comb begin
      // A count left over from a longer length starts again from zero.
      start_count = (count >= length) ? '0 : count;
      if (pattern_byte(pattern, start_count[2:0]) == data) begin
         next_count = len_type'(start_count + len_type'(1));
      end else if (start_count != '0 &&
                   pattern_byte(pattern, 3'd0) == data) begin
         next_count = len_type'(1);
      end else begin
         next_count = '0;
      end
      result.done  = (next_count == length);
      result.count = result.done ? '0 : next_count;
   end

endmodule

[dv/head_tail_frame_extractor_tb.sv]
// Self-checking testbench of head_tail_frame_extractor: directed and random byte streams,
// frame prediction and result checking, random idling and one long receiver hold-off.
// Depends on hte_pkg, the hte_if channel interfaces and the extractor RTL.
module head_tail_frame_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hte_pkg::*;

   localparam int unsigned MAX_HEAD      = 8;
   localparam int unsigned MAX_TAIL      = 8;
   localparam int unsigned SETTLE_CYCLES = 2 * MAX_HEAD + 4;
   localparam int unsigned LONG_HOLD     = 150;
   localparam int unsigned PHASE_BYTES   = 70;
   localparam int unsigned RANDOM_PHASES = 6;
   // Generous ceiling on the whole run, in nanoseconds.
   localparam longint     WATCHDOG_NS   = 5_000_000;
   // An index that names no register; writes to it must leave the block untouched.
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_SPARE = 8'hA5;

   // One byte of an extracted frame together with its frame marks.
   typedef struct packed {
      byte_type value;
      logic     first_mark;
      logic     last_mark;
   } frame_beat_type;

   logic clock;
   logic reset;

   hte_req_if req_if ();
   hte_rsp_if rsp_if ();
   hte_csr_if csr_if ();

   head_tail_frame_extractor #(
      .MAX_HEAD_BYTES (MAX_HEAD),
      .MAX_TAIL_BYTES (MAX_TAIL)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Our own copy of the register file and of the running match state.
   len_type     cfg_head_len;
   pattern_type cfg_head_pat;
   len_type     cfg_tail_len;
   pattern_type cfg_tail_pat;
   bit          in_frame;
   int unsigned match_count;

   frame_beat_type frame_beats_due[$];
   byte_type       bytes_to_send[$];
   int unsigned    bytes_pushed;
   int unsigned    bytes_taken;
   int unsigned    mismatches;

   // Stimulus controls shared with the driving processes.
   bit          idle_enable;
   bit          hold_request;
   bit          hold_done;
   int unsigned hold_left;
   int unsigned send_gap;
   int unsigned send_run;
   int unsigned stall_left;
   int unsigned ready_run;
   logic        req_fire;
   byte_type    sym_a;
   byte_type    sym_b;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A length of zero behaves as one, anything above the limit as the limit.
   function automatic int unsigned span(len_type len, int unsigned limit);
      if (len == '0) begin
         return 1;
      end
      if (int'(len) > limit) begin
         return limit;
      end
      return int'(len);
   endfunction

   // Naive restart matcher: on a mismatch the count drops to zero and the same byte is
   // tried once more against the first pattern byte. Returns 1 when the pattern completes.
   function automatic bit match_advance(pattern_type pat, int unsigned len, byte_type b);
      if (match_count >= len) begin
         match_count = 0;
      end
      if (pat[8*match_count +: 8] == b) begin
         match_count++;
      end else if (match_count != 0) begin
         match_count = 0;
         if (pat[7:0] == b) begin
            match_count = 1;
         end
      end
      if (match_count == len) begin
         match_count = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the frame bytes that one accepted input byte gives rise to.
   function automatic void extract_byte(byte_type b);
      int unsigned    hl;
      int unsigned    tl;
      bit             done;
      frame_beat_type beat;
      if (!in_frame) begin
         hl = span(cfg_head_len, MAX_HEAD);
         if (match_advance(cfg_head_pat, hl, b)) begin
            // The whole head is replayed from the register, first byte marked.
            for (int unsigned j = 0; j < hl; j++) begin
               beat.value      = cfg_head_pat[8*j +: 8];
               beat.first_mark = (j == 0);
               beat.last_mark  = 1'b0;
               frame_beats_due.push_back(beat);
            end
            in_frame    = 1'b1;
            match_count = 0;
         end
      end else begin
         tl              = span(cfg_tail_len, MAX_TAIL);
         done            = match_advance(cfg_tail_pat, tl, b);
         beat.value      = b;
         beat.first_mark = 1'b0;
         beat.last_mark  = done;
         frame_beats_due.push_back(beat);
         if (done) begin
            in_frame    = 1'b0;
            match_count = 0;
         end
      end
   endfunction

   // Input driver. A new byte is offered at the falling edge once the previous one has
   // been transferred; between runs of bytes it may pause at random while idling is enabled.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.in_byte <= '0;
      end else if (req_fire || !req_if.valid) begin
         if (send_gap != 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (bytes_to_send.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (idle_enable && send_run == 0) begin
            // This cycle is the first of the pause, and send_gap counts the rest of it.
            send_gap     = $urandom_range(0, 17);
            send_run     = $urandom_range(0, 30);
            req_if.valid <= 1'b0;
         end else begin
            if (send_run != 0) begin
               send_run--;
            end
            req_if.valid   <= 1'b1;
            req_if.in_byte <= bytes_to_send.pop_front();
         end
      end
   end

   // Receiver. It stalls in random bursts while idling is enabled and, once asked, holds
   // off once, for a length set by LONG_HOLD, as soon as a result is waiting, so that
   // the block backs up and stops taking input bytes while the driver keeps offering them.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_request && !hold_done && rsp_if.valid) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_enable && ready_run == 0) begin
         stall_left = $urandom_range(0, 17);
         ready_run  = $urandom_range(0, 30);
         rsp_if.ready <= 1'b0;
      end else begin
         if (ready_run != 0) begin
            ready_run--;
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor. Results are checked before the byte transferred at the same edge is
   // predicted, since a byte can never produce a result in its own cycle.
   always @(posedge clock) begin
      frame_beat_type expected;
      frame_beat_type actual;
      bit             wrong;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            actual.value      = rsp_if.out_byte;
            actual.first_mark = rsp_if.frame_first;
            actual.last_mark  = rsp_if.frame_last;
            if (frame_beats_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: expected none, actual %h first %b last %b",
                        $time, actual.value, actual.first_mark, actual.last_mark);
            end else begin
               expected = frame_beats_due.pop_front();
               wrong    = 1'b0;
               if (actual.value !== expected.value) begin
                  wrong = 1'b1;
               end
               if (actual.first_mark !== expected.first_mark) begin
                  wrong = 1'b1;
               end
               if (actual.last_mark !== expected.last_mark) begin
                  wrong = 1'b1;
               end
               if (wrong) begin
                  mismatches++;
                  $display("%0t: mismatch (byte first last): expected %h %b %b, actual %h %b %b",
                           $time, expected.value, expected.first_mark, expected.last_mark,
                           actual.value, actual.first_mark, actual.last_mark);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            extract_byte(req_if.in_byte);
            bytes_taken++;
         end
      end
   end

   task automatic push_byte(byte_type b);
      bytes_to_send.push_back(b);
      bytes_pushed++;
   endtask

   // Writes one register and, once the transfer has happened, updates our copy of it.
   task automatic write_register(logic [CSR_ADDR_W-1:0] index, pattern_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      case (index)
         CSR_HEAD_LENGTH:  cfg_head_len = value[LEN_W-1:0];
         CSR_HEAD_PATTERN: cfg_head_pat = value;
         CSR_TAIL_LENGTH:  cfg_tail_len = value[LEN_W-1:0];
         CSR_TAIL_PATTERN: cfg_tail_pat = value;
         default: ;
      endcase
   endtask

   task automatic release_config();
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Waits until every byte has been transferred and every frame byte has come back, then
   // lets the block settle: a byte that produced nothing may still be in flight.
   task automatic drain();
      while (!(bytes_taken == bytes_pushed && frame_beats_due.size() == 0)) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Lengths are mostly legal, with a share of zero and of too large values.
   function automatic len_type pick_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return len_type'($urandom_range(9, 15));
         default: return len_type'($urandom_range(1, 8));
      endcase
   endfunction

   // Patterns built from a two-symbol alphabet make the restart cases frequent.
   function automatic pattern_type make_pattern();
      pattern_type pat;
      case ($urandom_range(0, 5))
         0:       pat = '0;
         1:       pat = '1;
         2, 3:    pat = {$urandom, $urandom};
         default: begin
            for (int j = 0; j < 8; j++) begin
               pat[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            end
         end
      endcase
      return pat;
   endfunction

   function automatic byte_type noise_byte();
      case ($urandom_range(0, 4))
         0:       return sym_a;
         1:       return sym_b;
         2:       return cfg_tail_pat[7:0];
         default: return byte_type'($urandom);
      endcase
   endfunction

   // Mostly whole frames with random surroundings and payload; the rest are heads or
   // tails cut short by a stray byte.
   task automatic push_random_stream(int unsigned count);
      int unsigned start;
      int unsigned hl;
      int unsigned tl;
      int unsigned n;
      int unsigned kind;
      start = bytes_pushed;
      hl    = span(cfg_head_len, MAX_HEAD);
      tl    = span(cfg_tail_len, MAX_TAIL);
      while (bytes_pushed - start < count) begin
         kind = $urandom_range(0, 9);
         repeat ($urandom_range(0, 3)) push_byte(noise_byte());
         if (kind < 7) begin
            for (int unsigned j = 0; j < hl; j++) begin
               push_byte(cfg_head_pat[8*j +: 8]);
            end
            repeat ($urandom_range(0, 10)) push_byte(noise_byte());
            for (int unsigned j = 0; j < tl; j++) begin
               push_byte(cfg_tail_pat[8*j +: 8]);
            end
         end else if (kind < 9) begin
            n = $urandom_range(0, hl - 1);
            for (int unsigned j = 0; j < n; j++) begin
               push_byte(cfg_head_pat[8*j +: 8]);
            end
            push_byte(noise_byte());
         end else begin
            n = $urandom_range(0, tl - 1);
            for (int unsigned j = 0; j < n; j++) begin
               push_byte(cfg_tail_pat[8*j +: 8]);
            end
            push_byte(noise_byte());
         end
      end
   endtask

   initial begin
      pattern_type value;
      len_type     head_len;
      len_type     tail_len;

      // The configuration port is quiet from time zero and the driving processes settle
      // their outputs during reset; the predictor starts from the reset register values.
      reset          = 1'b1;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      cfg_head_len   = len_type'(1);
      cfg_head_pat   = '0;
      cfg_tail_len   = len_type'(1);
      cfg_tail_pat   = '0;
      in_frame       = 1'b0;
      match_count    = 0;
      bytes_pushed   = 0;
      bytes_taken    = 0;
      mismatches     = 0;
      idle_enable    = 1'b1;
      hold_request   = 1'b0;
      hold_done      = 1'b0;
      hold_left      = 0;
      send_gap       = 0;
      send_run       = 0;
      stall_left     = 0;
      ready_run      = 0;
      sym_a          = 8'h5A;
      sym_b          = 8'hA5;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset registers a lone zero byte is the head and the next zero ends the
      // frame, so first and last marks fall on neighbouring results, never on one.
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h00);
      drain();

      // A zero head length acts as one; a tail length of fifteen acts as eight. The third
      // tail byte breaks the match but restarts it at once as the first pattern byte.
      write_register(CSR_HEAD_LENGTH, '0);
      write_register(CSR_HEAD_PATTERN, '1);
      write_register(CSR_TAIL_LENGTH, '1);
      write_register(CSR_TAIL_PATTERN, 64'h0706_0504_0302_0100);
      release_config();
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h01);
      for (int j = 0; j < 8; j++) begin
         push_byte(byte_type'(j));
      end
      drain();

      // Leave the head matcher three bytes into an eight-byte head, with a zero tail length.
      write_register(CSR_HEAD_LENGTH, 64'd8);
      write_register(CSR_HEAD_PATTERN, 64'h8877_6655_4433_2211);
      write_register(CSR_TAIL_LENGTH, '0);
      write_register(CSR_TAIL_PATTERN, 64'h0000_0000_0000_00AA);
      release_config();
      push_byte(8'h11);
      push_byte(8'h22);
      push_byte(8'h33);
      drain();

      // Shortening the head below the count already matched clears the count first.
      write_register(CSR_HEAD_LENGTH, 64'd2);
      release_config();
      push_byte(8'h11);
      push_byte(8'h22);
      push_byte(8'hAA);
      drain();

      // A head length above the limit acts as eight, and a write to an unused index has
      // no effect on any register.
      write_register(CSR_HEAD_LENGTH, 64'hF);
      write_register(CSR_INDEX_SPARE, '1);
      release_config();
      for (int j = 1; j <= 8; j++) begin
         push_byte(byte_type'(j * 8'h11));
      end
      push_byte(8'hAA);
      drain();

      // Random phases. The first runs with the shortest sequences and the last with the
      // longest and without any idling; the second carries the long receiver hold-off.
      // Match state is deliberately carried from one phase into the next.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         sym_a = $urandom;
         sym_b = $urandom;
         if (phase == 0) begin
            head_len = len_type'(1);
            tail_len = len_type'(1);
         end else if (phase == RANDOM_PHASES - 1) begin
            head_len = len_type'(8);
            tail_len = len_type'(15);
            idle_enable = 1'b0;
         end else begin
            head_len = pick_length();
            tail_len = pick_length();
         end
         // Upper bits of the length data are random; only the low four bits count.
         value          = {$urandom, $urandom};
         value[LEN_W-1:0] = head_len;
         write_register(CSR_HEAD_LENGTH, value);
         write_register(CSR_HEAD_PATTERN, make_pattern());
         value          = {$urandom, $urandom};
         value[LEN_W-1:0] = tail_len;
         write_register(CSR_TAIL_LENGTH, value);
         write_register(CSR_TAIL_PATTERN, make_pattern());
         if ($urandom_range(0, 1)) begin
            write_register(
               CSR_ADDR_W'($urandom_range(CSR_TAIL_PATTERN + 1, {CSR_ADDR_W{1'b1}})),
               {$urandom, $urandom});
         end
         release_config();
         push_random_stream(PHASE_BYTES);
         if (phase == 1) begin
            hold_request = 1'b1;
         end
         drain();
      end

      // Anything still expected after the settling time never arrived.
      while (frame_beats_due.size() != 0) begin
         frame_beat_type missing;
         missing = frame_beats_due.pop_front();
         mismatches++;
         $display("%0t: missing result: expected byte %h first %b last %b, actual none",
                  $time, missing.value, missing.first_mark, missing.last_mark);
      end

      if (mismatches == 0) begin
         $display("head_tail_frame_extractor verification clean");
      end else begin
         $display("head_tail_frame_extractor verification failed");
      end
      $finish;
   end

   // Ends a run that hangs, whatever the reason.
   initial begin
      #(WATCHDOG_NS);
      $display("head_tail_frame_extractor verification failed");
      $finish;
   end

endmodule

[files.f]
sv/hte_pkg.sv
sv/hte_if.sv
sv/hte_matcher.sv
sv/head_tail_frame_extractor.sv
dv/head_tail_frame_extractor_tb.sv
